FILE: rtl/fcwd_pkg.sv
`timescale 1ns / 1ps

package fcwd_pkg;

  // Character codes of the dictionary alphabet.
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_Q = 8'h71;
  localparam logic [7:0] CH_U = 8'h75;

  // Result field widths.
  localparam int CHAR_W = 8;
  localparam int CIDX_W = 5;
  localparam int WLEN_W = 6;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_U,
    ST_READ,
    ST_SEND
  } state_t;

endpackage

FILE: rtl/front_coded_word_decoder.sv
`timescale 1ns / 1ps

// Front-coded word decoder. Takes a front-compressed word list one byte per item: a byte
// below 'a' is a shared-prefix count that closes the word in progress and keeps that many
// leading characters for the next word; any other byte is a letter appended to the word
// store, and a 'q' gets a 'u' inserted after it. tlast on an input item flushes the final
// word. A completed word comes out as one item per character with its index, the word
// length, tlast on the final character and tuser set when characters were dropped because
// the store was full. After a 'q' the input is held while its 'u' is written, as the store
// has a single write port. Each character of a completed word is read from the store and
// then loaded into the output register, which waits out any output stall; no input item
// is taken during the readout. The store reads as zero after reset without a clearing pass.
module front_coded_word_decoder #(
  parameter int MAX_WORD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_dict
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [fcwd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
                                     // [7:0] out_char, [12:8] char_index,
                                     // [18:13] word_len, [23:19] zero
  output logic       m_axis_tlast,   // word_last
  output logic       m_axis_tuser    // truncated
);

  localparam int IDXW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int POSW = $clog2(MAX_WORD + 1);
  localparam logic [POSW-1:0] POS_MAX = POSW'(MAX_WORD);

  fcwd_pkg::state_t state, state_next;

  // Word store with one write port and one registered read port.
  logic [7:0]          store [MAX_WORD];
  logic [MAX_WORD-1:0] written;
  logic [7:0]          rd_data;
  logic                rd_written;

  logic [POSW-1:0] write_pos;
  logic            word_open;
  logic            overflowed;
  logic            pend_end;
  logic [POSW-1:0] emit_len;
  logic            emit_trunc;
  logic [POSW-1:0] rd_pos;

  logic [fcwd_pkg::CHAR_W-1:0] out_char;
  logic [fcwd_pkg::CIDX_W-1:0] out_cidx;
  logic [fcwd_pkg::WLEN_W-1:0] out_wlen;
  logic                        out_last;
  logic                        out_trunc;

  logic            accept;
  logic            is_letter;
  logic            is_q;
  logic            room;
  logic [POSW-1:0] pos_inc;
  logic            ovf_set;
  logic [POSW-1:0] prefix_len;
  logic            wr_en;
  logic [7:0]      wr_data;
  logic            load_out;
  logic            last_char;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign is_letter  = (s_axis_tdata >= fcwd_pkg::CH_A);
  assign is_q       = (s_axis_tdata == fcwd_pkg::CH_Q);
  assign room       = (write_pos < POS_MAX);
  assign pos_inc    = room ? write_pos + POSW'(1) : write_pos;
  assign ovf_set    = overflowed || !room;
  assign prefix_len = (s_axis_tdata > 8'(MAX_WORD)) ? POS_MAX : POSW'(s_axis_tdata);
  assign last_char  = (rd_pos + POSW'(1) == emit_len);

  always_comb begin
    state_next = state;
    unique case (state)
      fcwd_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_letter) begin
            if (is_q) state_next = fcwd_pkg::ST_INS_U;
            else if (s_axis_tlast) state_next = fcwd_pkg::ST_READ;
          end else if (word_open && write_pos != '0) begin
            state_next = fcwd_pkg::ST_READ;
          end
        end
      end
      fcwd_pkg::ST_INS_U: begin
        state_next = pend_end ? fcwd_pkg::ST_READ : fcwd_pkg::ST_IDLE;
      end
      fcwd_pkg::ST_READ: begin
        state_next = fcwd_pkg::ST_SEND;
      end
      fcwd_pkg::ST_SEND: begin
        if (load_out) state_next = last_char ? fcwd_pkg::ST_IDLE : fcwd_pkg::ST_READ;
      end
      default: state_next = fcwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    wr_en         = 1'b0;
    wr_data       = s_axis_tdata;
    load_out      = 1'b0;
    unique case (state)
      fcwd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        wr_en         = accept && is_letter && room;
      end
      fcwd_pkg::ST_INS_U: begin
        wr_en   = room;
        wr_data = fcwd_pkg::CH_U;
      end
      fcwd_pkg::ST_READ: begin
      end
      fcwd_pkg::ST_SEND: begin
        load_out = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[write_pos[IDXW-1:0]] <= wr_data;
    rd_data <= store[rd_pos[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) written[write_pos[IDXW-1:0]] <= 1'b1;
      rd_written <= written[rd_pos[IDXW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fcwd_pkg::ST_IDLE;
      write_pos  <= '0;
      word_open  <= 1'b0;
      overflowed <= 1'b0;
      pend_end   <= 1'b0;
      emit_len   <= '0;
      emit_trunc <= 1'b0;
      rd_pos     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        fcwd_pkg::ST_IDLE: begin
          if (accept) begin
            rd_pos <= '0;
            if (is_letter) begin
              pend_end <= s_axis_tlast;
              if (s_axis_tlast && !is_q) begin
                emit_len   <= pos_inc;
                emit_trunc <= ovf_set;
                write_pos  <= '0;
                overflowed <= 1'b0;
                word_open  <= 1'b0;
              end else begin
                write_pos  <= pos_inc;
                overflowed <= ovf_set;
                word_open  <= 1'b1;
              end
            end else begin
              emit_len   <= write_pos;
              emit_trunc <= overflowed;
              overflowed <= 1'b0;
              write_pos  <= s_axis_tlast ? '0 : prefix_len;
              word_open  <= !s_axis_tlast;
            end
          end
        end
        fcwd_pkg::ST_INS_U: begin
          if (pend_end) begin
            emit_len   <= pos_inc;
            emit_trunc <= ovf_set;
            write_pos  <= '0;
            overflowed <= 1'b0;
            word_open  <= 1'b0;
          end else begin
            write_pos  <= pos_inc;
            overflowed <= ovf_set;
          end
        end
        fcwd_pkg::ST_READ: begin
        end
        fcwd_pkg::ST_SEND: begin
          if (load_out) rd_pos <= rd_pos + POSW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: holds a finished character until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char  <= rd_written ? rd_data : '0;
      out_cidx  <= fcwd_pkg::CIDX_W'(rd_pos);
      out_wlen  <= fcwd_pkg::WLEN_W'(emit_len);
      out_last  <= last_char;
      out_trunc <= emit_trunc;
    end
  end

  assign m_axis_tdata = {
    (fcwd_pkg::OUT_DATA_W - fcwd_pkg::CHAR_W - fcwd_pkg::CIDX_W - fcwd_pkg::WLEN_W)'(0),
    out_wlen, out_cidx, out_char
  };
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_trunc;

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state == fcwd_pkg::ST_READ || state == fcwd_pkg::ST_SEND) |-> !wr_en)
    else $error("store written during word readout");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    write_pos <= POS_MAX)
    else $error("write position beyond store capacity");

  a_read_in_word: assert property (@(posedge clk) disable iff (rst)
    (state == fcwd_pkg::ST_READ) |-> (emit_len != '0 && rd_pos < emit_len))
    else $error("readout position outside the word");

  a_last_ends_readout: assert property (@(posedge clk) disable iff (rst)
    (load_out && last_char) |=> (state == fcwd_pkg::ST_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("final character did not end the readout");

endmodule
